// File: sv/sias_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sias_pkg
// Command, status and register codes plus fp32 constants for the scaled
// index-add scatter block.
// ----------------------------------------------------------------------------
package sias_pkg;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_ACC  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_SKIP  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [2:0] REG_ALPHA     = 3'd0;
  localparam logic [2:0] REG_DIM       = 3'd1;
  localparam logic [2:0] REG_INNER     = 3'd2;
  localparam logic [2:0] REG_INDEX_LEN = 3'd3;
  localparam logic [2:0] REG_OUTER     = 3'd4;

  localparam logic [12:0] SIZE_MAX   = 13'd4096;
  localparam logic [31:0] ALPHA_ONE  = 32'h3F80_0000;
  localparam logic [31:0] QNAN_DEF   = 32'hFFC0_0000;
  localparam logic [31:0] QUIET_BIT  = 32'h0040_0000;
  localparam logic signed [10:0] FP_BIAS = 11'sd127;

endpackage

// File: sv/scaled_index_add_scatter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_index_add_scatter_top
// fp32 index-add scatter accumulate over an on-chip output store.
//
// Input stream: tuser carries the command (load, accumulate, read), tdata the
// address, the fp32 data and the signed row index. Every input transaction
// gives exactly one output transaction: tdata is the fp32 value read or
// written back, tuser the status (done, index skipped, address beyond store).
// Registers (alpha, dim, inner, index length, outer) are written over the APB
// port; the user must write them only while the block is idle, as the block
// itself does not enforce it. The block takes one transaction at a time;
// in_tready is high only when idle. A full accumulate runs address product
// steps, one store read, then the shared fp unit runs multiply and add through
// the same eight-step normalize sequence and rounding. A NaN or infinity
// operand skips that sequence for the multiply or add that it affects.
// A finished result waits in the output register while out_tready is low;
// the next transaction is accepted meanwhile and held at its end until the
// register is free.
// Reset (rst_n low, synchronous) clears the position counters and output valid
// and sets alpha to 1.0 and dim and sizes to 1; the store is undefined until loaded.
// ----------------------------------------------------------------------------
module scaled_index_add_scatter_top
  import sias_pkg::*;
#(
  parameter int STORE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // address[11:0], data_value[43:12], index_value[75:44]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // read_value[31:0]
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = $clog2(STORE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_IDX, S_AD1, S_AD2, S_RDA, S_RDV, S_MUL, S_ALN, S_NRM, S_RND, S_WR, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0]  cmd_r, cmd_nxt;
  logic [39:0] addr_r, addr_nxt;
  logic [31:0] data_r, data_nxt;
  logic [31:0] idx_r, idx_nxt;
  logic [11:0] idxw_r, idxw_nxt;
  logic [24:0] p1_r, p1_nxt;
  logic [38:0] t_r, t_nxt;
  logic [11:0] inner_sv_r, inner_sv_nxt;
  logic [31:0] rv_r, rv_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic        s_r, s_nxt;
  logic signed [10:0] e_r, e_nxt;
  logic [49:0] m_r, m_nxt;
  logic        stk_r, stk_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        phase_r, phase_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic [1:0]  out_user_r, out_user_nxt;
  logic [11:0] outer_pos_r, outer_pos_nxt;
  logic [11:0] row_pos_r, row_pos_nxt;
  logic [11:0] inner_pos_r, inner_pos_nxt;
  logic [31:0] alpha_r, alpha_nxt;
  logic [12:0] dim_r, dim_nxt;
  logic [12:0] inner_size_r, inner_size_nxt;
  logic [12:0] index_len_r, index_len_nxt;
  logic [12:0] outer_size_r, outer_size_nxt;

  logic [31:0] mem [STORE_DEPTH];
  logic [31:0] rdata_r;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0] mem_wd;

  logic        in_acc, cfg_wr;
  logic [11:0] in_addr;
  logic [31:0] in_data, in_idx;
  logic [39:0] ld_addr;
  logic        ld_ok;
  logic [12:0] dim_eff, inn_eff, len_eff, out_eff;

  // arithmetic temporaries
  logic [32:0] idxs, idxwr;
  logic        idx_ok;
  logic [39:0] acc_a;
  logic [7:0]  ea, eb, ex, ey, ebig, esml, dsh;
  logic [23:0] ma, mb, mx, my, mbig, msml;
  logic        nan_a, nan_b, inf_a, inf_b, zer_a, zer_b;
  logic        nan_x, nan_y, inf_x, inf_y, sbig, x_big;
  logic [47:0] prd;
  logic [5:0]  shk, shc;
  logic signed [10:0] shv;
  logic [99:0] sh100;
  logic [49:0] mbw, msw, sumw;
  logic [23:0] rmant;
  logic        rg, rst_b, rinc;
  logic [24:0] r25;
  logic [23:0] mant2;
  logic signed [10:0] e2;
  logic [31:0] res;

  function automatic logic [12:0] count_size(input logic [12:0] v);
    if (v == 13'd0) return 13'd1;
    if (v > SIZE_MAX) return SIZE_MAX;
    return v;
  endfunction

  assign in_addr = in_tdata[11:0];
  assign in_data = in_tdata[43:12];
  assign in_idx  = in_tdata[75:44];
  assign in_acc  = in_tvalid && in_tready;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign ld_addr = {28'd0, in_addr};
  assign ld_ok   = ld_addr < 40'(STORE_DEPTH);

  assign dim_eff = (dim_r > SIZE_MAX) ? SIZE_MAX : dim_r;
  assign inn_eff = count_size(inner_size_r);
  assign len_eff = count_size(index_len_r);
  assign out_eff = count_size(outer_size_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_ALPHA:     cfg_prdata = alpha_r;
      REG_DIM:       cfg_prdata = {19'd0, dim_r};
      REG_INNER:     cfg_prdata = {19'd0, inner_size_r};
      REG_INDEX_LEN: cfg_prdata = {19'd0, index_len_r};
      REG_OUTER:     cfg_prdata = {19'd0, outer_size_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  assign mem_we = (state_r == S_WR) || (in_acc && (in_tuser == CMD_LOAD) && ld_ok);
  assign mem_wa = (state_r == S_WR) ? addr_r[AW-1:0] : ld_addr[AW-1:0];
  assign mem_wd = (state_r == S_WR) ? rv_r : in_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[addr_r[AW-1:0]];
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    addr_nxt       = addr_r;
    data_nxt       = data_r;
    idx_nxt        = idx_r;
    idxw_nxt       = idxw_r;
    p1_nxt         = p1_r;
    t_nxt          = t_r;
    inner_sv_nxt   = inner_sv_r;
    rv_nxt         = rv_r;
    st_nxt         = st_r;
    prod_nxt       = prod_r;
    s_nxt          = s_r;
    e_nxt          = e_r;
    m_nxt          = m_r;
    stk_nxt        = stk_r;
    step_nxt       = step_r;
    phase_nxt      = phase_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    outer_pos_nxt  = outer_pos_r;
    row_pos_nxt    = row_pos_r;
    inner_pos_nxt  = inner_pos_r;
    alpha_nxt      = alpha_r;
    dim_nxt        = dim_r;
    inner_size_nxt = inner_size_r;
    index_len_nxt  = index_len_r;
    outer_size_nxt = outer_size_r;

    idxs = 33'd0; idxwr = 33'd0; idx_ok = 1'b0; acc_a = 40'd0;
    ea = 8'd0; eb = 8'd0; ex = 8'd0; ey = 8'd0; ebig = 8'd0; esml = 8'd0; dsh = 8'd0;
    ma = 24'd0; mb = 24'd0; mx = 24'd0; my = 24'd0; mbig = 24'd0; msml = 24'd0;
    nan_a = 1'b0; nan_b = 1'b0; inf_a = 1'b0; inf_b = 1'b0; zer_a = 1'b0; zer_b = 1'b0;
    nan_x = 1'b0; nan_y = 1'b0; inf_x = 1'b0; inf_y = 1'b0; sbig = 1'b0; x_big = 1'b0;
    prd = 48'd0; shk = 6'd0; shc = 6'd0; shv = 11'sd0; sh100 = 100'd0;
    mbw = 50'd0; msw = 50'd0; sumw = 50'd0;
    rmant = 24'd0; rg = 1'b0; rst_b = 1'b0; rinc = 1'b0; r25 = 25'd0;
    mant2 = 24'd0; e2 = 11'sd0; res = 32'd0;

    if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_ALPHA:     alpha_nxt      = cfg_pwdata;
        REG_DIM:       dim_nxt        = cfg_pwdata[12:0];
        REG_INNER:     inner_size_nxt = cfg_pwdata[12:0];
        REG_INDEX_LEN: index_len_nxt  = cfg_pwdata[12:0];
        REG_OUTER:     outer_size_nxt = cfg_pwdata[12:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = in_tuser;
          data_nxt = in_data;
          idx_nxt  = in_idx;
          addr_nxt = ld_addr;
          rv_nxt   = 32'd0;
          st_nxt   = ST_DONE;
          case (in_tuser)
            CMD_LOAD: begin
              st_nxt    = ld_ok ? ST_DONE : ST_RANGE;
              state_nxt = S_FIN;
            end
            CMD_READ: begin
              st_nxt    = ld_ok ? ST_DONE : ST_RANGE;
              state_nxt = ld_ok ? S_RDA : S_FIN;
            end
            CMD_ACC: state_nxt = S_IDX;
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_IDX: begin
        idxs  = {idx_r[31], idx_r};
        idxwr = idx_r[31] ? (idxs + {20'd0, dim_eff}) : idxs;
        idx_ok = !idxwr[32] && (idxwr < {20'd0, dim_eff});
        idxw_nxt     = idxwr[11:0];
        p1_nxt       = outer_pos_r * dim_eff;
        inner_sv_nxt = inner_pos_r;
        if (({1'b0, inner_pos_r} + 13'd1) >= inn_eff) begin
          inner_pos_nxt = 12'd0;
          if (({1'b0, row_pos_r} + 13'd1) >= len_eff) begin
            row_pos_nxt = 12'd0;
            if (({1'b0, outer_pos_r} + 13'd1) >= out_eff) begin
              outer_pos_nxt = 12'd0;
            end else begin
              outer_pos_nxt = outer_pos_r + 12'd1;
            end
          end else begin
            row_pos_nxt = row_pos_r + 12'd1;
          end
        end else begin
          inner_pos_nxt = inner_pos_r + 12'd1;
        end
        if (idx_ok) begin
          state_nxt = S_AD1;
        end else begin
          st_nxt    = ST_SKIP;
          state_nxt = S_FIN;
        end
      end
      S_AD1: begin
        t_nxt     = (26'(p1_r) + 26'(idxw_r)) * inn_eff;
        state_nxt = S_AD2;
      end
      S_AD2: begin
        acc_a = 40'(t_r) + 40'(inner_sv_r);
        if (acc_a < 40'(STORE_DEPTH)) begin
          addr_nxt  = acc_a;
          state_nxt = S_RDA;
        end else begin
          st_nxt    = ST_RANGE;
          state_nxt = S_FIN;
        end
      end
      S_RDA: state_nxt = S_RDV;
      S_RDV: begin
        rv_nxt    = rdata_r;
        state_nxt = (cmd_r == CMD_READ) ? S_FIN : S_MUL;
      end
      S_MUL: begin
        ea = (data_r[30:23] == 8'd0) ? 8'd1 : data_r[30:23];
        eb = (alpha_r[30:23] == 8'd0) ? 8'd1 : alpha_r[30:23];
        ma = {data_r[30:23] != 8'd0, data_r[22:0]};
        mb = {alpha_r[30:23] != 8'd0, alpha_r[22:0]};
        nan_a = (data_r[30:23] == 8'hFF) && (data_r[22:0] != 23'd0);
        nan_b = (alpha_r[30:23] == 8'hFF) && (alpha_r[22:0] != 23'd0);
        inf_a = (data_r[30:23] == 8'hFF) && (data_r[22:0] == 23'd0);
        inf_b = (alpha_r[30:23] == 8'hFF) && (alpha_r[22:0] == 23'd0);
        zer_a = (data_r[30:0] == 31'd0);
        zer_b = (alpha_r[30:0] == 31'd0);
        prd   = ma * mb;
        phase_nxt = 1'b0;
        if (nan_a) begin
          prod_nxt = data_r | QUIET_BIT;  state_nxt = S_ALN;
        end else if (nan_b) begin
          prod_nxt = alpha_r | QUIET_BIT; state_nxt = S_ALN;
        end else if ((inf_a && zer_b) || (inf_b && zer_a)) begin
          prod_nxt = QNAN_DEF;            state_nxt = S_ALN;
        end else if (inf_a || inf_b) begin
          prod_nxt = {data_r[31] ^ alpha_r[31], 8'hFF, 23'd0};
          state_nxt = S_ALN;
        end else begin
          s_nxt     = data_r[31] ^ alpha_r[31];
          e_nxt     = $signed({3'd0, ea}) + $signed({3'd0, eb}) - FP_BIAS;
          m_nxt     = {prd, 2'b00};
          stk_nxt   = 1'b0;
          step_nxt  = 3'd0;
          state_nxt = S_NRM;
        end
      end
      S_ALN: begin
        ex = (rv_r[30:23] == 8'd0) ? 8'd1 : rv_r[30:23];
        ey = (prod_r[30:23] == 8'd0) ? 8'd1 : prod_r[30:23];
        mx = {rv_r[30:23] != 8'd0, rv_r[22:0]};
        my = {prod_r[30:23] != 8'd0, prod_r[22:0]};
        nan_x = (rv_r[30:23] == 8'hFF) && (rv_r[22:0] != 23'd0);
        nan_y = (prod_r[30:23] == 8'hFF) && (prod_r[22:0] != 23'd0);
        inf_x = (rv_r[30:23] == 8'hFF) && (rv_r[22:0] == 23'd0);
        inf_y = (prod_r[30:23] == 8'hFF) && (prod_r[22:0] == 23'd0);
        x_big = {ex, mx} >= {ey, my};
        ebig  = x_big ? ex : ey;
        esml  = x_big ? ey : ex;
        mbig  = x_big ? mx : my;
        msml  = x_big ? my : mx;
        sbig  = x_big ? rv_r[31] : prod_r[31];
        dsh   = ebig - esml;
        shc   = (dsh > 8'd50) ? 6'd50 : dsh[5:0];
        mbw   = {1'b0, mbig, 25'd0};
        sh100 = {1'b0, msml, 25'd0, 50'd0} >> shc;
        msw   = sh100[99:50] | {49'd0, |sh100[49:0]};
        sumw  = (rv_r[31] == prod_r[31]) ? (mbw + msw) : (mbw - msw);
        phase_nxt = 1'b1;
        if (nan_x) begin
          rv_nxt = rv_r | QUIET_BIT;   state_nxt = S_WR;
        end else if (nan_y) begin
          rv_nxt = prod_r | QUIET_BIT; state_nxt = S_WR;
        end else if (inf_x && inf_y && (rv_r[31] != prod_r[31])) begin
          rv_nxt = QNAN_DEF;           state_nxt = S_WR;
        end else if (inf_x) begin
          rv_nxt = rv_r;               state_nxt = S_WR;
        end else if (inf_y) begin
          rv_nxt = prod_r;             state_nxt = S_WR;
        end else begin
          s_nxt     = (sumw == 50'd0) ? (rv_r[31] & prod_r[31]) : sbig;
          e_nxt     = $signed({3'd0, ebig});
          m_nxt     = sumw;
          stk_nxt   = 1'b0;
          step_nxt  = 3'd0;
          state_nxt = S_NRM;
        end
      end
      S_NRM: begin
        step_nxt = step_r + 3'd1;
        case (step_r)
          3'd0: begin
            if (m_r[49]) begin
              m_nxt   = {1'b0, m_r[49:1]};
              stk_nxt = stk_r | m_r[0];
              e_nxt   = e_r + 11'sd1;
            end
          end
          3'd7: begin
            if (e_r < 11'sd1) begin
              shv     = 11'sd1 - e_r;
              shc     = (shv > 11'sd50) ? 6'd50 : shv[5:0];
              sh100   = {m_r, 50'd0} >> shc;
              m_nxt   = sh100[99:50];
              stk_nxt = stk_r | (|sh100[49:0]);
              e_nxt   = 11'sd1;
            end
            state_nxt = S_RND;
          end
          default: begin
            shk = 6'd32 >> (step_r - 3'd1);
            if (((m_r >> (6'd49 - shk)) == 50'd0) && (e_r > $signed({5'd0, shk}))) begin
              m_nxt = m_r << shk;
              e_nxt = e_r - $signed({5'd0, shk});
            end
          end
        endcase
      end
      S_RND: begin
        rmant = m_r[48:25];
        rg    = m_r[24];
        rst_b = (|m_r[23:0]) | stk_r;
        rinc  = rg && (rst_b || rmant[0]);
        r25   = {1'b0, rmant} + 25'(rinc);
        if (r25[24]) begin
          mant2 = r25[24:1];
          e2    = e_r + 11'sd1;
        end else begin
          mant2 = r25[23:0];
          e2    = e_r;
        end
        if (e2 >= 11'sd255) begin
          res = {s_r, 8'hFF, 23'd0};
        end else begin
          res = {s_r, (mant2[23] ? e2[7:0] : 8'd0), mant2[22:0]};
        end
        if (phase_r) begin
          rv_nxt    = res;
          state_nxt = S_WR;
        end else begin
          prod_nxt  = res;
          state_nxt = S_ALN;
        end
      end
      S_WR: begin
        st_nxt    = ST_DONE;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = rv_r;
          out_user_nxt   = st_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      outer_pos_r  <= 12'd0;
      row_pos_r    <= 12'd0;
      inner_pos_r  <= 12'd0;
      alpha_r      <= ALPHA_ONE;
      dim_r        <= 13'd1;
      inner_size_r <= 13'd1;
      index_len_r  <= 13'd1;
      outer_size_r <= 13'd1;
      step_r       <= 3'd0;
      phase_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      outer_pos_r  <= outer_pos_nxt;
      row_pos_r    <= row_pos_nxt;
      inner_pos_r  <= inner_pos_nxt;
      alpha_r      <= alpha_nxt;
      dim_r        <= dim_nxt;
      inner_size_r <= inner_size_nxt;
      index_len_r  <= index_len_nxt;
      outer_size_r <= outer_size_nxt;
      step_r       <= step_nxt;
      phase_r      <= phase_nxt;
    end
    cmd_r      <= cmd_nxt;
    addr_r     <= addr_nxt;
    data_r     <= data_nxt;
    idx_r      <= idx_nxt;
    idxw_r     <= idxw_nxt;
    p1_r       <= p1_nxt;
    t_r        <= t_nxt;
    inner_sv_r <= inner_sv_nxt;
    rv_r       <= rv_nxt;
    st_r       <= st_nxt;
    prod_r     <= prod_nxt;
    s_r        <= s_nxt;
    e_r        <= e_nxt;
    m_r        <= m_nxt;
    stk_r      <= stk_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule
